@@ design/ssmv_pkg.sv @@
`timescale 1ns / 1ps

package ssmv_pkg;

   localparam int DEF_VECTOR_DEPTH  = 1024;
   localparam int DEF_STENCIL_SLOTS = 16;
   localparam int DEF_STENCIL_WORDS = 32;

   localparam logic [2:0] CMD_WORD = 3'd0;
   localparam logic [2:0] CMD_STEP = 3'd1;
   localparam logic [2:0] CMD_ROW  = 3'd2;
   localparam logic [2:0] CMD_X    = 3'd3;
   localparam logic [2:0] CMD_Y    = 3'd4;
   localparam logic [2:0] CMD_RUN  = 3'd5;
   localparam logic [2:0] CMD_READ = 3'd6;

   localparam logic [2:0] CSR_ALPHA = 3'd0;
   localparam logic [2:0] CSR_BETA  = 3'd1;
   localparam logic [2:0] CSR_TRANS = 3'd2;
   localparam logic [2:0] CSR_ROWS  = 3'd3;
   localparam logic [2:0] CSR_COLS  = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE, S_RDZ,
      S_SC_RD, S_SC_MUL, S_SC_WR,
      S_ROW_RD, S_ROW_MAP,
      S_HD_RD, S_HD_CHK,
      S_TX_RD, S_TX_M1, S_TX_M2, S_TX_M3, S_TX_M4,
      S_K_RD, S_K_CHK, S_TZ_WR, S_PX_ACC,
      S_PL_M1, S_PL_M2, S_PL_M3, S_PL_M4, S_PL_WR,
      S_STEP
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round half up, floor shift, then saturate
   function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
      logic signed [63:0] q;
      q = (p + 64'sd32768) >>> 16;
      return sat32(q);
   endfunction

endpackage

@@ design/stencil_sparse_matrix_vector_mac.sv @@
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tuser: command; tdata: index, stencil_id, offset, data
// rsp      out  rsp_tvalid/rsp_tready  tdata: read_index, read_value
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// Load requests write their memory when taken; a read looks up z, then registers the response.
// A run first scales each z entry it walks by beta (read, multiply, write back), then for
// each row reads the row map, walks the stencil's groups in either mode (header, alpha
// scaling, offsets that hit an in-range column) and, for a mapped stencil, steps the base.
// Reset idles control and sets configuration to its defaults; memories hold garbage until loaded.
// req_tready stays low while a run or a read is in progress or a read result cannot be placed.

module stencil_sparse_matrix_vector_mac #(
   parameter int VECTOR_DEPTH  = ssmv_pkg::DEF_VECTOR_DEPTH,
   parameter int STENCIL_SLOTS = ssmv_pkg::DEF_STENCIL_SLOTS,
   parameter int STENCIL_WORDS = ssmv_pkg::DEF_STENCIL_WORDS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // command
   input  logic [55:0] req_tdata,  // index[9:0], stencil_id[13:10], offset_or_count[23:14],
                                   // data[55:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // read_index[9:0], read_value[41:10], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ssmv_pkg::*;

   localparam int VA  = $clog2(VECTOR_DEPTH);
   localparam int CW  = VA + 1;
   localparam int SD  = STENCIL_SLOTS * STENCIL_WORDS;
   localparam int SA  = $clog2(SD);
   localparam int PW  = $clog2(STENCIL_WORDS) + 1;
   localparam int SIW = (STENCIL_SLOTS > 1) ? $clog2(STENCIL_SLOTS) : 1;

   // memories
   logic [41:0]        st_mem [SD];
   logic [3:0]         rm_mem [VECTOR_DEPTH];
   logic signed [31:0] x_mem  [VECTOR_DEPTH];
   logic signed [31:0] z_mem  [VECTOR_DEPTH];
   logic [7:0]         step_mem [STENCIL_SLOTS];

   logic               st_we, st_re, rm_we, rm_re, x_we, x_re, z_we, z_re, step_we;
   logic [SA-1:0]      st_waddr, st_raddr;
   logic [41:0]        st_wdata, st_rd;
   logic [VA-1:0]      rm_waddr, rm_raddr, x_waddr, x_raddr, z_waddr, z_raddr;
   logic [3:0]         rm_rd;
   logic signed [31:0] x_wdata, x_rd, z_wdata, z_rd;
   logic [SIW-1:0]     step_waddr;

   // config
   logic signed [31:0] alpha_ff, beta_ff;
   logic               trans_ff;
   logic [10:0]        rows_cfg_ff, cols_cfg_ff;

   // control and datapath
   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;       // scale index, then row
   logic [3:0]         sid_ff, sid_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [9:0]         k_ff, k_in;
   logic [8:0]         n_ff, n_in;
   logic signed [31:0] coef_ff, coef_in, t_ff, t_in;
   logic signed [40:0] sum_ff, sum_in;
   logic [15:0]        base_ff, base_in;
   logic [VA-1:0]      c_ff, c_in;
   logic [9:0]         rd_idx_ff, rd_idx_in;
   logic               rd_oor_ff, rd_oor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [41:0]        rsp_data_ff, rsp_data_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] mul_a, mul_b;

   // request fields
   logic [2:0]         cmd;
   logic [9:0]         idx;
   logic [3:0]         sid;
   logic signed [9:0]  off;
   logic signed [31:0] dat;
   logic               req_fire, idx_ok;
   logic [VA-1:0]      idx_addr;
   logic [CW-1:0]      rows, cols, scale_n;
   logic signed [9:0]  st_off;
   logic signed [17:0] col;
   logic [16:0]        base_sum;

   assign cmd = req_tuser;
   assign idx = req_tdata[9:0];
   assign sid = req_tdata[13:10];
   assign off = req_tdata[23:14];
   assign dat = req_tdata[55:24];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign idx_ok     = 32'(idx) < VECTOR_DEPTH;
   assign idx_addr   = VA'(idx);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   assign rows    = (32'(rows_cfg_ff) > VECTOR_DEPTH) ? CW'(VECTOR_DEPTH) : CW'(rows_cfg_ff);
   assign cols    = (32'(cols_cfg_ff) > VECTOR_DEPTH) ? CW'(VECTOR_DEPTH) : CW'(cols_cfg_ff);
   assign scale_n = trans_ff ? cols : rows;
   assign st_off  = st_rd[9:0];
   assign col     = $signed({2'b0, base_ff}) + 18'(st_off);
   assign base_sum = {1'b0, base_ff} + 17'(step_mem[SIW'(sid_ff)]);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sid_in      = sid_ff;
      pos_in      = pos_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      coef_in     = coef_ff;
      t_in        = t_ff;
      sum_in      = sum_ff;
      base_in     = base_ff;
      c_in        = c_ff;
      rd_idx_in   = rd_idx_ff;
      rd_oor_in   = rd_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mul_a       = t_ff;
      mul_b       = coef_ff;
      st_we = 1'b0; st_re = 1'b0; rm_we = 1'b0; rm_re = 1'b0;
      x_we  = 1'b0; x_re  = 1'b0; z_we  = 1'b0; z_re  = 1'b0; step_we = 1'b0;
      st_waddr   = SA'(32'(sid) * STENCIL_WORDS + 32'(idx));
      st_raddr   = SA'(32'(sid_ff) * STENCIL_WORDS + 32'(pos_ff));
      st_wdata   = {dat, off};
      rm_waddr   = idx_addr;
      rm_raddr   = cnt_ff[VA-1:0];
      x_waddr    = idx_addr;
      x_raddr    = cnt_ff[VA-1:0];
      x_wdata    = dat;
      z_waddr    = idx_addr;
      z_raddr    = cnt_ff[VA-1:0];
      z_wdata    = dat;
      step_waddr = SIW'(sid);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_WORD: st_we = (32'(sid) < STENCIL_SLOTS) && (32'(idx) < STENCIL_WORDS);
                  CMD_STEP: step_we = 32'(sid) < STENCIL_SLOTS;
                  CMD_ROW:  rm_we = idx_ok;
                  CMD_X:    x_we = idx_ok;
                  CMD_Y:    z_we = idx_ok;
                  CMD_RUN: begin
                     cnt_in   = '0;
                     state_in = S_SC_RD;
                  end
                  CMD_READ: begin
                     z_re      = 1'b1;
                     z_raddr   = idx_addr;
                     rd_idx_in = idx;
                     rd_oor_in = !idx_ok;
                     state_in  = S_RDZ;
                  end
                  default: ;
               endcase
            end
         end
         S_RDZ: begin
            rsp_data_in  = {rd_oor_ff ? 32'sd0 : z_rd, rd_idx_ff};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SC_RD: begin
            if (cnt_ff >= scale_n) begin
               cnt_in   = '0;
               base_in  = '0;
               state_in = S_ROW_RD;
            end else begin
               z_re     = 1'b1;
               state_in = S_SC_MUL;
            end
         end
         S_SC_MUL: begin
            mul_a    = beta_ff;
            mul_b    = z_rd;
            state_in = S_SC_WR;
         end
         S_SC_WR: begin
            z_we     = 1'b1;
            z_waddr  = cnt_ff[VA-1:0];
            z_wdata  = qsat(prod_ff);
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_SC_RD;
         end
         S_ROW_RD: begin
            if (cnt_ff >= rows) begin
               state_in = S_IDLE;
            end else begin
               rm_re    = 1'b1;
               state_in = S_ROW_MAP;
            end
         end
         S_ROW_MAP: begin
            sid_in = rm_rd;
            pos_in = '0;
            if (32'(rm_rd) < STENCIL_SLOTS) begin
               state_in = S_HD_RD;
            end else begin
               // unmapped stencil: empty row, base holds
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_ROW_RD;
            end
         end
         S_HD_RD: begin
            if (32'(pos_ff) >= STENCIL_WORDS) begin
               state_in = S_STEP;
            end else begin
               st_re    = 1'b1;
               state_in = S_HD_CHK;
            end
         end
         S_HD_CHK: begin
            if (st_off <= 10'sd0) begin
               state_in = S_STEP;
            end else begin
               coef_in  = st_rd[41:10];
               n_in     = st_off[8:0];
               k_in     = '0;
               sum_in   = '0;
               pos_in   = pos_ff + 1'b1;
               state_in = trans_ff ? S_TX_RD : S_K_RD;
            end
         end
         S_TX_RD: begin
            x_re     = 1'b1;
            state_in = S_TX_M1;
         end
         S_TX_M1: begin
            mul_a    = alpha_ff;
            mul_b    = x_rd;
            state_in = S_TX_M2;
         end
         S_TX_M2: begin
            t_in     = qsat(prod_ff);
            state_in = S_TX_M3;
         end
         S_TX_M3: state_in = S_TX_M4;
         S_TX_M4: begin
            t_in     = qsat(prod_ff);
            state_in = S_K_RD;
         end
         S_K_RD: begin
            if (k_ff >= {1'b0, n_ff} || 32'(pos_ff) >= STENCIL_WORDS) begin
               state_in = trans_ff ? S_HD_RD : S_PL_M1;
            end else begin
               st_re    = 1'b1;
               state_in = S_K_CHK;
            end
         end
         S_K_CHK: begin
            pos_in = pos_ff + 1'b1;
            k_in   = k_ff + 1'b1;
            c_in   = col[VA-1:0];
            if (col >= 18'sd0 && col < $signed({1'b0, 17'(cols)})) begin
               if (trans_ff) begin
                  z_re     = 1'b1;
                  z_raddr  = col[VA-1:0];
                  state_in = S_TZ_WR;
               end else begin
                  x_re     = 1'b1;
                  x_raddr  = col[VA-1:0];
                  state_in = S_PX_ACC;
               end
            end else begin
               state_in = S_K_RD;
            end
         end
         S_TZ_WR: begin
            z_we     = 1'b1;
            z_waddr  = c_ff;
            z_wdata  = sat32(64'(z_rd) + 64'(t_ff));
            state_in = S_K_RD;
         end
         S_PX_ACC: begin
            sum_in   = sum_ff + 41'(x_rd);
            state_in = S_K_RD;
         end
         S_PL_M1: begin
            t_in     = sat32(64'(sum_ff));
            state_in = S_PL_M2;
         end
         S_PL_M2: begin
            mul_a    = alpha_ff;
            mul_b    = t_ff;
            state_in = S_PL_M3;
         end
         S_PL_M3: begin
            t_in     = qsat(prod_ff);
            state_in = S_PL_M4;
         end
         S_PL_M4: begin
            z_re     = 1'b1;
            state_in = S_PL_WR;
         end
         S_PL_WR: begin
            z_we     = 1'b1;
            z_waddr  = cnt_ff[VA-1:0];
            z_wdata  = sat32(64'(z_rd) + 64'(qsat(prod_ff)));
            state_in = S_HD_RD;
         end
         S_STEP: begin
            base_in  = base_sum[16] ? 16'hFFFF : base_sum[15:0];
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_ROW_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         alpha_ff     <= 32'sd65536;
         beta_ff      <= '0;
         trans_ff     <= 1'b0;
         rows_cfg_ff  <= 11'd1;
         cols_cfg_ff  <= 11'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALPHA: alpha_ff    <= csr_data;
               CSR_BETA:  beta_ff     <= csr_data;
               CSR_TRANS: trans_ff    <= csr_data[0];
               CSR_ROWS:  rows_cfg_ff <= csr_data[10:0];
               CSR_COLS:  cols_cfg_ff <= csr_data[10:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      sid_ff      <= sid_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      coef_ff     <= coef_in;
      t_ff        <= t_in;
      sum_ff      <= sum_in;
      c_ff        <= c_in;
      rd_idx_ff   <= rd_idx_in;
      rd_oor_ff   <= rd_oor_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[st_waddr] <= st_wdata;
      if (st_re) st_rd <= st_mem[st_raddr];
      if (rm_we) rm_mem[rm_waddr] <= sid;
      if (rm_re) rm_rd <= rm_mem[rm_raddr];
      if (x_we) x_mem[x_waddr] <= x_wdata;
      if (x_re) x_rd <= x_mem[x_raddr];
      if (z_we) z_mem[z_waddr] <= z_wdata;
      if (z_re) z_rd <= z_mem[z_raddr];
      if (step_we) step_mem[step_waddr] <= dat[7:0];
   end

endmodule

@@ design/ssmv_checker.sv @@
`timescale 1ns / 1ps

module ssmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic [55:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   import ssmv_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == CMD_READ |=> ##1
      rsp_tvalid && rsp_tdata[9:0] == $past(req_tdata[9:0], 2))
      else $error("read request gave no matching response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser != CMD_READ && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response without read request");

   a_run_stall: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == CMD_RUN |=> !req_tready)
      else $error("request taken during run");

endmodule

bind stencil_sparse_matrix_vector_mac ssmv_checker u_ssmv_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import ssmv_pkg::*;

   localparam int WORDS      = DEF_STENCIL_WORDS;
   localparam int SLOTS      = DEF_STENCIL_SLOTS;
   localparam int DEPTH      = DEF_VECTOR_DEPTH;
   localparam int IDLE_LIMIT = 400000;
   localparam int RAND_ITEMS = 1750;

   // Tracks loaded stores and configuration, computes z on each run and
   // holds the read responses still owed by the block.
   class z_scoreboard;
      int alpha, beta, rows_cfg, cols_cfg;
      bit trans;
      int st_off[SLOTS*WORDS];
      int st_coef[SLOTS*WORDS];
      int step[SLOTS];
      int rmap[DEPTH];
      int xv[DEPTH];
      int zv[DEPTH];
      bit row_done[DEPTH];
      bit x_done[DEPTH];
      bit z_done[DEPTH];
      logic [9:0]  want_idx[$];
      logic [31:0] want_val[$];
      int errors;

      function new();
         alpha = 65536;
         beta = 0;
         trans = 0;
         rows_cfg = 1;
         cols_cfg = 1;
         errors = 0;
      endfunction

      function int sat(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function int qm(int a, int b);
         longint p;
         p = longint'(a) * longint'(b) + 32768;
         return sat(p >>> 16);
      endfunction

      function void set_reg(logic [2:0] r, logic [31:0] v);
         case (r)
            CSR_ALPHA: alpha = int'(v);
            CSR_BETA:  beta = int'(v);
            CSR_TRANS: trans = v[0];
            CSR_ROWS:  rows_cfg = v[10:0];
            CSR_COLS:  cols_cfg = v[10:0];
            default: ;
         endcase
      endfunction

      function void multiply();
         int rows, cols, r, sid, pos, n, coef, term, k, bw;
         longint sum, c, base;
         rows = rows_cfg > DEPTH ? DEPTH : rows_cfg;
         cols = cols_cfg > DEPTH ? DEPTH : cols_cfg;
         r = trans ? cols : rows;
         for (int i = 0; i < r; i++) zv[i] = (beta == 0) ? 0 : qm(beta, zv[i]);
         base = 0;
         for (int row = 0; row < rows; row++) begin
            sid = rmap[row];
            bw = sid * WORDS;
            pos = 0;
            while (pos < WORDS) begin
               n = st_off[bw+pos];
               coef = st_coef[bw+pos];
               if (n <= 0) break;
               pos++;
               sum = 0;
               term = trans ? qm(qm(alpha, xv[row]), coef) : 0;
               for (k = 0; k < n && pos < WORDS; k++) begin
                  c = base + st_off[bw+pos];
                  pos++;
                  if (c < 0 || c >= cols) continue;
                  if (trans) zv[c] = sat(longint'(zv[c]) + term);
                  else sum += xv[c];
               end
               if (!trans) zv[row] = sat(longint'(zv[row]) + qm(qm(alpha, sat(sum)), coef));
            end
            base += step[sid];
            if (base > 65535) base = 65535;
         end
      endfunction

      function void note_request(logic [2:0] cmd, logic [9:0] idx, logic [3:0] sid,
                                 logic signed [9:0] oc, logic [31:0] data);
         case (cmd)
            CMD_WORD: if (idx < WORDS) begin
               st_off[sid*WORDS+idx] = oc;
               st_coef[sid*WORDS+idx] = int'(data);
            end
            CMD_STEP: step[sid] = data[7:0];
            CMD_ROW: begin
               rmap[idx] = sid;
               row_done[idx] = 1;
            end
            CMD_X: begin
               xv[idx] = int'(data);
               x_done[idx] = 1;
            end
            CMD_Y: begin
               zv[idx] = int'(data);
               z_done[idx] = 1;
            end
            CMD_RUN: multiply();
            CMD_READ: begin
               want_idx.push_back(idx);
               want_val.push_back(zv[idx]);
            end
            default: ;
         endcase
      endfunction

      function void check_read(logic [9:0] idx, logic [31:0] val);
         logic [9:0]  ei;
         logic [31:0] ev;
         if (want_idx.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected read response idx=%0d val=%h", idx, val);
            return;
         end
         ei = want_idx.pop_front();
         ev = want_val.pop_front();
         if (ei !== idx || ev !== val) begin
            errors++;
            if (errors <= 10)
               $display("read mismatch: expected idx=%0d val=%h, got idx=%0d val=%h",
                        ei, ev, idx, val);
         end
      endfunction

      function int pending();
         return want_idx.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [2:0]  req_tuser = 0;
   logic [55:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   z_scoreboard sb = new();
   int burst_left = 0;
   int items = 0;
   int prep_hi = 0;
   int idle_cycles = 0;
   int cyc = 0;

   stencil_sparse_matrix_vector_mac u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: cycle through always-ready, mostly-ready, sparse and bursty stalls
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_read(rsp_tdata[9:0], rsp_tdata[41:10]);
      case ((cyc / 256) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= (cyc % 4) != 0;
         2: rsp_tready <= $urandom_range(0, 9) < 3;
         default: rsp_tready <= (cyc % 16) < 5;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] rnd_val();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      endcase
   endfunction

   task automatic send(logic [2:0] cmd, logic [9:0] idx, logic [3:0] sid,
                       logic [9:0] oc, logic [31:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {data, oc, sid, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, idx, sid, oc, data);
      burst_left--;
      items++;
   endtask

   // hold until every read has returned and any run has finished
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0 || !req_tready);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_cfg(int alpha, int beta, int trans, int rows, int cols);
      logic [31:0] vals[5];
      vals = '{alpha, beta, trans, rows, cols};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(i[2:0], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // header and offset groups, then at times a terminator, then junk that is never walked
   task automatic gen_stencil(int sid);
      int left, ended;
      logic [9:0] oc;
      left = 0;
      ended = 0;
      for (int pos = 0; pos < WORDS; pos++) begin
         if (ended) begin
            send(CMD_WORD, pos, sid, $urandom, $urandom);
         end else if (left > 0) begin
            case ($urandom_range(0, 15))
               0: oc = 10'h1FF;
               1: oc = 10'h200;
               default: oc = $urandom_range(0, 20) - 4;
            endcase
            send(CMD_WORD, pos, sid, oc, $urandom);
            left--;
         end else if (pos > 0 && $urandom_range(0, 3) == 0) begin
            oc = $urandom_range(0, 1) ? 10'd0 : 10'(-$urandom_range(1, 512));
            send(CMD_WORD, pos, sid, oc, $urandom);
            ended = 1;
         end else begin
            left = ($urandom_range(0, 15) == 0) ? 511 : $urandom_range(1, 4);
            send(CMD_WORD, pos, sid, left, rnd_val());
         end
      end
      send(CMD_STEP, 0, sid, $urandom, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
   endtask

   task automatic prep(int n);
      if (n > DEPTH) n = DEPTH;
      for (int i = 0; i < n; i++) begin
         if (!sb.row_done[i]) send(CMD_ROW, i, $urandom, $urandom, $urandom);
         if (!sb.x_done[i]) send(CMD_X, i, $urandom, $urandom, rnd_val());
         if (!sb.z_done[i]) send(CMD_Y, i, $urandom, $urandom, rnd_val());
      end
      if (n > prep_hi) prep_hi = n;
   endtask

   task automatic read_some(int n);
      for (int i = 0; i < n; i++) send(CMD_READ, $urandom_range(0, prep_hi - 1), $urandom,
                                       $urandom, $urandom);
   endtask

   task automatic phase(int alpha, int beta, int trans, int rows, int cols, int nload);
      int need, lim;
      settle();
      write_cfg(alpha, beta, trans, rows, cols);
      need = (rows > cols) ? rows : cols;
      prep(need);
      lim = (need < 1) ? 1 : (need > DEPTH ? DEPTH : need);
      for (int i = 0; i < nload; i++) begin
         case ($urandom_range(0, 11))
            0, 1, 2: send(CMD_X, $urandom_range(0, lim - 1), $urandom, $urandom, rnd_val());
            3, 4:    send(CMD_Y, $urandom_range(0, lim - 1), $urandom, $urandom, rnd_val());
            5:       send(CMD_ROW, $urandom_range(0, lim - 1), $urandom, $urandom, $urandom);
            6:       send(CMD_WORD, $urandom_range(0, 40), $urandom, $urandom, $urandom);
            7:       send(CMD_STEP, $urandom, $urandom, $urandom, $urandom);
            8:       send(3'd7, $urandom, $urandom, $urandom, $urandom);
            9:       gen_stencil($urandom_range(0, SLOTS - 1));
            default: read_some(1);
         endcase
      end
      send(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
      read_some($urandom_range(2, 8));
   endtask

   function automatic int pick_gain();
      case ($urandom_range(0, 5))
         0: return 65536;
         1: return 0;
         2: return $urandom;
         3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      endcase
   endfunction

   function automatic int pick_count();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return $urandom_range(25, 80);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int s = 0; s < SLOTS; s++) gen_stencil(s);

      // reset configuration, ignored word load, unused command
      prep(1);
      send(CMD_READ, 0, 0, 0, 0);
      send(CMD_WORD, 1023, 4'hF, 10'h1FF, 32'hFFFFFFFF);
      send(CMD_WORD, WORDS, 0, 10'h200, 0);
      send(3'd7, 10'h3FF, 4'hF, 10'h3FF, 32'hFFFFFFFF);
      send(CMD_RUN, 0, 0, 0, 0);
      send(CMD_READ, 0, 0, 0, 0);

      phase(32'h7FFFFFFF, 32'h80000000, 1, 8, 8, 4);
      phase(32'h80000000, 32'h7FFFFFFF, 0, 8, 8, 4);
      phase(65536, 65536, 0, 0, 5, 2);
      phase(65536, 0, 1, 3, 0, 2);

      // column count clamped; base plus offset runs past the last column
      settle();
      write_cfg(65536, 65536, 0, 4, 2047);
      send(CMD_WORD, 0, 15, 2, 65536);
      send(CMD_WORD, 1, 15, 0, 0);
      send(CMD_WORD, 2, 15, 511, 0);
      send(CMD_WORD, 3, 15, 0, 0);
      send(CMD_STEP, 0, 15, 0, 255);
      for (int i = 0; i < 4; i++) begin
         send(CMD_ROW, i, 15, 0, 0);
         send(CMD_X, 10'(i * 255), 0, 0, rnd_val());
         if (i < 3) send(CMD_X, 10'(i * 255 + 511), 0, 0, rnd_val());
      end
      prep(4);
      send(CMD_RUN, 0, 0, 0, 0);
      send(CMD_READ, 3, 0, 0, 0);
      read_some(6);
      settle();
      gen_stencil(15);
      for (int i = 0; i < 64; i++) send(CMD_ROW, i, $urandom, 0, 0);

      while (items < RAND_ITEMS)
         phase(pick_gain(), pick_gain(), $urandom_range(0, 1), pick_count(), pick_count(),
               $urandom_range(5, 40));

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
design/ssmv_pkg.sv
design/stencil_sparse_matrix_vector_mac.sv
design/ssmv_checker.sv
tb/tb_top.sv
